### hdl/mbet_pkg.sv
// Shared types, constants and fixed-point helpers for the escape-time block.
// Used by mbet_mul, mbet_div and mandelbrot_escape_time_top; no dependencies.
`default_nettype none

package mbet_pkg;

    localparam int WORD_W      = 32;
    localparam int PROD_W      = 64;
    localparam int PIX_W       = 16;
    localparam int CFG_W       = 29;
    localparam int ITER_W      = 10;
    localparam int SHADE_W     = 17;
    localparam int QUOT_BITS   = 16;
    localparam int DCNT_W      = $clog2(QUOT_BITS + 1);
    localparam int ADDR_W      = 4;
    localparam int APB_W       = 32;

    localparam int FRAC_BITS   = 20;
    localparam int COORD_SHIFT = 9;
    localparam int ITER_LIMIT  = 512;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [PROD_W-1:0] FOUR    = 64'sd4 <<< FRAC_BITS;
    localparam logic [SHADE_W-1:0]       SHADE_ONE = SHADE_W'(1) << QUOT_BITS;

    typedef enum logic [1:0] {
        REG_VIEW_RE  = 2'd0,
        REG_VIEW_IM  = 2'd1,
        REG_ZOOM     = 2'd2,
        REG_MAX_ITER = 2'd3
    } t_reg_idx;

    typedef enum logic {
        SH_FRAC,
        SH_FRAC_M1
    } t_shift;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_MAP_C,
        ST_SQ_R,
        ST_SQ_I,
        ST_CROSS,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] num;
        logic [ITER_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 valid;
        logic [QUOT_BITS-1:0] quot;
    } t_div_rsp;

    // Clamp a wide signed value to the signed 32-bit word.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > SAT_MAX) begin
            return WORD_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return WORD_W'(SAT_MIN);
        end
        return WORD_W'(v);
    endfunction

    // Pixel to fixed point, divided by 2^COORD_SHIFT with floor rounding.
    function automatic logic signed [WORD_W-1:0] map_pix(input logic signed [PIX_W-1:0] pix);
        logic signed [PROD_W-1:0] w;
        w = PROD_W'(pix);
        w = (w <<< FRAC_BITS) >>> COORD_SHIFT;
        return sat32(w);
    endfunction

endpackage

`default_nettype wire

### hdl/mandelbrot_escape_time_top.sv
// Mandelbrot escape-time evaluator: one pixel in, one escape result out.
// Channels: s_axis takes a pixel, tdata = {pixel_y, pixel_x}. m_axis returns
// tdata = {pad, shade_value, escaped, escape_count}. APB port holds the view
// origin, zoom and iteration bound (byte addresses 0x0, 0x4, 0x8, 0xC).
// One multiplier is time-shared: states MAP_X, MAP_Y and MAP_C map the pixel
// to c, then each z = z*z + c step runs through SQ_R, SQ_I, CROSS and UPDATE
// (zr*zr, zi*zi, zr*zi, update). A point that escapes also waits for the shade
// division before its result is ready. One pixel is in work at a time:
// s_axis_tready is high only while idle, so the next pixel is taken at best in
// the cycle after the previous result is registered.
// The finished result sits in an output register; the next pixel is accepted
// while it waits. If the receiver stalls, a second finished result holds in
// the sequencer until the output register frees.
// Reset (synchronous, active low) drops both valid flags, idles the sequencer
// and restores the register defaults.
// Depends on mbet_pkg, mbet_mul and mbet_div.
`default_nettype none

module mandelbrot_escape_time_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [9:0] escape_count, [10] escaped,
                                             // [27:11] shade_value, [31:28] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbet_pkg::*;

    // configuration
    logic signed [CFG_W-1:0] r_view_re;
    logic signed [CFG_W-1:0] r_view_im;
    logic signed [CFG_W-1:0] r_zoom;
    logic [ITER_W-1:0]       r_max_iter;
    t_reg_idx                reg_idx;
    logic                    cfg_wr;

    // sequencer and datapath
    t_state                   r_state, n_state;
    logic signed [PIX_W-1:0]  r_pix_x, n_pix_x;
    logic signed [PIX_W-1:0]  r_pix_y, n_pix_y;
    logic [ITER_W-1:0]        r_bound, n_bound;
    logic [ITER_W-1:0]        r_n, n_n;
    logic signed [WORD_W-1:0] r_cr, n_cr;
    logic signed [WORD_W-1:0] r_ci, n_ci;
    logic signed [WORD_W-1:0] r_zr, n_zr;
    logic signed [WORD_W-1:0] r_zi, n_zi;
    logic signed [WORD_W-1:0] r_zr2, n_zr2;
    logic signed [WORD_W-1:0] r_zi2, n_zi2;
    logic [ITER_W-1:0]        r_count, n_count;
    logic                     r_escaped, n_escaped;
    logic [SHADE_W-1:0]       r_shade, n_shade;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic [ITER_W-1:0]        r_out_count, n_out_count;
    logic                     r_out_escaped, n_out_escaped;
    logic [SHADE_W-1:0]       r_out_shade, n_out_shade;

    // shared units
    logic signed [WORD_W-1:0] mul_a, mul_b, mul_res;
    t_shift                   mul_shift;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    mbet_mul u_mul (
        .i_clk   (i_clk),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_shift (mul_shift),
        .o_res   (mul_res)
    );

    mbet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- configuration port ----------------
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_re  <= -CFG_W'(1855980);
            r_view_im  <= '0;
            r_zoom     <= CFG_W'(3670016);
            r_max_iter <= ITER_W'(128);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_VIEW_RE:  r_view_re  <= pwdata[CFG_W-1:0];
                REG_VIEW_IM:  r_view_im  <= pwdata[CFG_W-1:0];
                REG_ZOOM:     r_zoom     <= pwdata[CFG_W-1:0];
                REG_MAX_ITER: r_max_iter <= pwdata[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VIEW_RE:  prdata = APB_W'(r_view_re);
            REG_VIEW_IM:  prdata = APB_W'(r_view_im);
            REG_ZOOM:     prdata = APB_W'(r_zoom);
            REG_MAX_ITER: prdata = APB_W'(r_max_iter);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        logic signed [PROD_W-1:0] mag2;
        logic signed [PROD_W-1:0] next_zr;
        logic signed [PROD_W-1:0] next_zi;
        logic signed [PROD_W-1:0] map_sum;

        n_state       = r_state;
        n_pix_x       = r_pix_x;
        n_pix_y       = r_pix_y;
        n_bound       = r_bound;
        n_n           = r_n;
        n_cr          = r_cr;
        n_ci          = r_ci;
        n_zr          = r_zr;
        n_zi          = r_zi;
        n_zr2         = r_zr2;
        n_zi2         = r_zi2;
        n_count       = r_count;
        n_escaped     = r_escaped;
        n_shade       = r_shade;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_count   = r_out_count;
        n_out_escaped = r_out_escaped;
        n_out_shade   = r_out_shade;

        mul_a         = r_zr;
        mul_b         = r_zr;
        mul_shift     = SH_FRAC;
        div_req.start = 1'b0;
        div_req.num   = r_count;
        div_req.den   = r_bound;

        mag2    = PROD_W'(r_zr2) + PROD_W'(mul_res);
        next_zr = PROD_W'(r_zr2) - PROD_W'(r_zi2) + PROD_W'(r_cr);
        next_zi = PROD_W'(mul_res) + PROD_W'(r_ci);
        map_sum = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_pix_x = s_axis_tdata[PIX_W-1:0];
                    n_pix_y = s_axis_tdata[2*PIX_W-1:PIX_W];
                    n_bound = (r_max_iter > ITER_W'(ITER_LIMIT)) ? ITER_W'(ITER_LIMIT)
                                                                 : r_max_iter;
                    n_state = ST_MAP_X;
                end
            end
            ST_MAP_X: begin
                mul_a   = map_pix(r_pix_x);
                mul_b   = WORD_W'(r_zoom);
                n_state = ST_MAP_Y;
            end
            ST_MAP_Y: begin
                mul_a   = map_pix(r_pix_y);
                mul_b   = WORD_W'(r_zoom);
                map_sum = PROD_W'(r_view_re) + PROD_W'(mul_res);
                n_cr    = sat32(map_sum);
                n_state = ST_MAP_C;
            end
            ST_MAP_C: begin
                map_sum = PROD_W'(r_view_im) + PROD_W'(mul_res);
                n_ci    = sat32(map_sum);
                n_zi    = sat32(map_sum);
                n_zr    = r_cr;
                n_n     = '0;
                n_state = ST_SQ_R;
            end
            ST_SQ_R: begin
                // bound reached without escape
                if (r_n == r_bound) begin
                    n_count   = r_bound;
                    n_escaped = 1'b0;
                    n_shade   = SHADE_ONE;
                    n_state   = ST_DONE;
                end else begin
                    mul_a   = r_zr;
                    mul_b   = r_zr;
                    n_state = ST_SQ_I;
                end
            end
            ST_SQ_I: begin
                mul_a   = r_zi;
                mul_b   = r_zi;
                n_zr2   = mul_res;
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                mul_a     = r_zr;
                mul_b     = r_zi;
                mul_shift = SH_FRAC_M1;
                n_zi2     = mul_res;
                if (mag2 > FOUR) begin
                    n_count       = r_n;
                    n_escaped     = 1'b1;
                    div_req.start = 1'b1;
                    div_req.num   = r_n;
                    n_state       = ST_DIVIDE;
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_zi    = sat32(next_zi);
                n_zr    = sat32(next_zr);
                n_n     = r_n + ITER_W'(1);
                n_state = ST_SQ_R;
            end
            ST_DIVIDE: begin
                if (div_rsp.valid) begin
                    n_shade = {1'b0, div_rsp.quot};
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register frees
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_count   = r_count;
                    n_out_escaped = r_escaped;
                    n_out_shade   = r_shade;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_x       <= n_pix_x;
        r_pix_y       <= n_pix_y;
        r_bound       <= n_bound;
        r_n           <= n_n;
        r_cr          <= n_cr;
        r_ci          <= n_ci;
        r_zr          <= n_zr;
        r_zi          <= n_zi;
        r_zr2         <= n_zr2;
        r_zi2         <= n_zi2;
        r_count       <= n_count;
        r_escaped     <= n_escaped;
        r_shade       <= n_shade;
        r_out_count   <= n_out_count;
        r_out_escaped <= n_out_escaped;
        r_out_shade   <= n_out_shade;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_shade, r_out_escaped, r_out_count};

endmodule

`default_nettype wire

### hdl/mbet_mul.sv
// Shared signed 32x32 multiplier with registered product, then floor shift and clamp.
// Depends on mbet_pkg.
`default_nettype none

module mbet_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [mbet_pkg::WORD_W-1:0] i_a,
    input  wire logic signed [mbet_pkg::WORD_W-1:0] i_b,
    input  wire mbet_pkg::t_shift                  i_shift,
    output logic signed [mbet_pkg::WORD_W-1:0]      o_res
);
    import mbet_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    t_shift                   r_shift;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(i_a) * PROD_W'(i_b);
        r_shift <= i_shift;
    end

    always_comb begin
        case (r_shift)
            SH_FRAC_M1: shifted = r_prod >>> (FRAC_BITS - 1);
            default:    shifted = r_prod >>> FRAC_BITS;
        endcase
        o_res = sat32(shifted);
    end

endmodule

`default_nettype wire

### hdl/mbet_div.sv
// Restoring divider for the shade value: floor(num * 2^16 / den), one bit a cycle.
// Expects num < den. Depends on mbet_pkg.
`default_nettype none

module mbet_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mbet_pkg::t_div_req i_req,
    output mbet_pkg::t_div_rsp      o_rsp
);
    import mbet_pkg::*;

    logic [ITER_W-1:0]    r_rem;
    logic [QUOT_BITS-1:0] r_quot;
    logic [DCNT_W-1:0]    r_cnt;
    logic                 r_valid;
    logic [ITER_W:0]      rem2;
    logic                 ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, i_req.den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else if (i_req.start) begin
            r_cnt   <= DCNT_W'(QUOT_BITS);
            r_valid <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= ge ? ITER_W'(rem2 - {1'b0, i_req.den}) : rem2[ITER_W-1:0];
            r_quot <= {r_quot[QUOT_BITS-2:0], ge};
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.quot  = r_quot;

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking bench for mandelbrot_escape_time_top: pixels on the input stream, APB view setup.
// An internal fixed-point predictor computes each escape result; depends on mbet_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import mbet_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 2100;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint ESCAPE_RADIUS_SQ = 64'sd4 <<< FRAC_BITS;
    localparam logic [SHADE_W-1:0] SHADE_FULL = 17'd65536;
    localparam int VIEW_EXTREME = 209715200;

    typedef struct {
        logic [ITER_W-1:0]  count;
        logic               escaped;
        logic [SHADE_W-1:0] shade;
    } t_escape_result;

    class escape_scoreboard;
        longint view_re;
        longint view_im;
        longint zoom;
        int unsigned iter_cfg;
        t_escape_result pending_results[$];
        int unsigned fail_count;

        function new();
            view_re = -1855980;
            view_im = 0;
            zoom = 3670016;
            iter_cfg = 128;
            fail_count = 0;
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_MAX) begin
                return WORD_MAX;
            end else if (v < WORD_MIN) begin
                return WORD_MIN;
            end
            return v;
        endfunction

        function longint map_axis(longint pix, longint origin);
            longint scaled;
            longint zoomed;
            scaled = clamp_word((pix <<< FRAC_BITS) >>> COORD_SHIFT);
            zoomed = clamp_word((scaled * zoom) >>> FRAC_BITS);
            return clamp_word(origin + zoomed);
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            logic signed [CFG_W-1:0] v29;
            v29 = value[CFG_W-1:0];
            case (idx)
                REG_VIEW_RE:  view_re = longint'(v29);
                REG_VIEW_IM:  view_im = longint'(v29);
                REG_ZOOM:     zoom = longint'(v29);
                REG_MAX_ITER: iter_cfg = {22'd0, value[ITER_W-1:0]};
                default: ;
            endcase
        endfunction

        // Iterate z = z*z + c for one accepted pixel and queue the outcome.
        function void add_pixel(logic signed [PIX_W-1:0] px, logic signed [PIX_W-1:0] py);
            longint cr, ci, zr, zi, zr2, zi2, cross_term;
            int unsigned bound;
            t_escape_result r;
            cr = map_axis(px, view_re);
            ci = map_axis(py, view_im);
            zr = cr;
            zi = ci;
            bound = (iter_cfg > ITER_LIMIT) ? ITER_LIMIT : iter_cfg;
            r.count = ITER_W'(bound);
            r.escaped = 1'b0;
            r.shade = SHADE_FULL;
            for (int unsigned n = 0; n < bound; n++) begin
                zr2 = clamp_word((zr * zr) >>> FRAC_BITS);
                zi2 = clamp_word((zi * zi) >>> FRAC_BITS);
                if (zr2 + zi2 > ESCAPE_RADIUS_SQ) begin
                    r.count = ITER_W'(n);
                    r.escaped = 1'b1;
                    r.shade = SHADE_W'((longint'(n) << 16) / bound);
                    break;
                end
                cross_term = clamp_word((zr * zi) >>> (FRAC_BITS - 1));
                zi = clamp_word(cross_term + ci);
                zr = clamp_word(zr2 - zi2 + cr);
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [ITER_W-1:0] count, logic escaped,
                                   logic [SHADE_W-1:0] shade);
            t_escape_result exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result: escape_count %0d, escaped %0d, shade_value %0d",
                       count, escaped, shade);
                fail_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (count !== exp_r.count) begin
                $error("escape_count: expected %0d, actual %0d", exp_r.count, count);
                fail_count++;
            end
            if (escaped !== exp_r.escaped) begin
                $error("escaped: expected %0d, actual %0d", exp_r.escaped, escaped);
                fail_count++;
            end
            if (shade !== exp_r.shade) begin
                $error("shade_value: expected %0d, actual %0d", exp_r.shade, shade);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] pixel_x, [31:16] pixel_y
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [9:0] escape_count, [10] escaped, [27:11] shade_value
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        no_idle = 1'b0;
    int unsigned cycle_count = 0;

    escape_scoreboard sb = new();

    mandelbrot_escape_time_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Check each result transaction, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[9:0], m_axis_tdata[10], m_axis_tdata[27:11]);
        end
        m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
    end

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic send_pixel(input logic signed [PIX_W-1:0] px,
                              input logic signed [PIX_W-1:0] py);
        int gap;
        gap = (no_idle || $urandom_range(99) >= 27) ? 0 : rand_between(1, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {py, px};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.add_pixel(px, py);
    endtask

    // Drop valid and hold until every queued pixel has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!(psel && penable && pwrite && pready));
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_view(input int vr, input int vi, input int zm, input int unsigned mi);
        program_reg(REG_VIEW_RE, 32'(vr));
        program_reg(REG_VIEW_IM, 32'(vi));
        program_reg(REG_ZOOM, 32'(zm));
        program_reg(REG_MAX_ITER, 32'(mi));
    endtask

    initial begin
        shortint corners[5];
        int unsigned mi;
        int n_items;
        int vr, vi, zm;
        int sel;
        logic signed [PIX_W-1:0] px, py;

        corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset view: field extremes, points inside and outside the set.
        send_pixel(0, 0);
        send_pixel(32767, 32767);
        send_pixel(-32768, -32768);
        send_pixel(32767, -32768);
        send_pixel(-32768, 32767);
        send_pixel(-1, -1);
        send_pixel(1, 1);
        send_pixel(259, 0);
        send_pixel(100, 0);
        send_pixel(259, 100);
        send_pixel(0, 146);
        send_pixel(512, -512);
        send_pixel(-256, 0);
        drain();

        // Zero iteration bound.
        program_reg(REG_MAX_ITER, 32'd0);
        send_pixel(259, 0);
        send_pixel(32767, -32768);
        drain();

        // Bound above the limit saturates.
        program_reg(REG_MAX_ITER, 32'd1023);
        send_pixel(259, 0);
        send_pixel(100, 0);
        drain();

        // Saturation of coordinates and products.
        set_view(VIEW_EXTREME, -VIEW_EXTREME, VIEW_EXTREME, 4);
        send_pixel(32767, -32768);
        send_pixel(-32768, 32767);
        send_pixel(0, 0);
        send_pixel(1, -1);
        drain();
        set_view(-VIEW_EXTREME, VIEW_EXTREME, -VIEW_EXTREME, 4);
        send_pixel(-32768, -32768);
        send_pixel(32767, 1);
        drain();

        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: mi = 512;
                1: mi = 0;
                2: mi = 1;
                3: mi = 1023;
                4: mi = 128;
                default: mi = rand_between(2, 60);
            endcase
            n_items = (ph == 0 || ph == 3) ? 6 : (ph == 4) ? 30 : 110;

            if (ph % 5 == 3) begin
                vr = ($urandom_range(1) != 0) ? VIEW_EXTREME : -VIEW_EXTREME;
                vi = ($urandom_range(1) != 0) ? VIEW_EXTREME : -VIEW_EXTREME;
            end else if (ph == 11) begin
                vr = rand_between(-VIEW_EXTREME, VIEW_EXTREME);
                vi = rand_between(-VIEW_EXTREME, VIEW_EXTREME);
            end else begin
                vr = rand_between(-2621440, 1048576);
                vi = rand_between(-1572864, 1572864);
            end
            if (ph % 4 == 2) begin
                zm = ($urandom_range(1) != 0) ? VIEW_EXTREME : -VIEW_EXTREME;
            end else if (ph == 11) begin
                zm = rand_between(-VIEW_EXTREME, VIEW_EXTREME);
            end else begin
                zm = rand_between(1 << 17, 1 << 23);
                if ($urandom_range(4) == 0) begin
                    zm = -zm;
                end
            end

            drain();
            set_view(vr, vi, zm, mi);
            no_idle <= (ph == 4 || ph == 8);

            for (int k = 0; k < n_items; k++) begin
                sel = $urandom_range(99);
                if (sel < 75) begin
                    px = PIX_W'(rand_between(-1024, 1023));
                    py = PIX_W'(rand_between(-1024, 1023));
                end else if (sel < 90) begin
                    px = PIX_W'($urandom());
                    py = PIX_W'($urandom());
                end else begin
                    px = corners[$urandom_range(4)];
                    py = corners[$urandom_range(4)];
                end
                send_pixel(px, py);
            end
        end

        drain();
        no_idle <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $error("%0d results never arrived", sb.pending_results.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
